// ----- hw/rtl/csx_pkg.sv -----
package csx_pkg;

    // table sizes
    localparam int NUM_FUNCS   = 64;
    localparam int STACK_DEPTH = 64;
    localparam int TIME_BITS   = 32;

    // field widths
    localparam int ID_W     = 6;
    localparam int TS_W     = 32;
    localparam int TOTAL_W  = 40;
    localparam int STATUS_W = 3;
    localparam int DEPTH_W  = 7;
    localparam int FCOUNT_W = 7;

    // derived widths
    localparam int FID_AW = $clog2(NUM_FUNCS);
    localparam int STK_AW = $clog2(STACK_DEPTH);
    localparam int SPAN_W = TIME_BITS + 1;
    localparam int ALU_W  = TOTAL_W + 2;

    // stream word widths
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 3;

    localparam logic [FCOUNT_W-1:0] FCOUNT_RESET = FCOUNT_W'(64);

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_BACK  = 3'd4;

    // saturation limits, sign-extended to the adder width
    localparam logic signed [ALU_W-1:0] TOTAL_MAX = ALU_W'((64'sd1 <<< (TOTAL_W - 1)) - 64'sd1);
    localparam logic signed [ALU_W-1:0] TOTAL_MIN = -TOTAL_MAX - ALU_W'(1);

    // one call stack entry
    typedef struct packed {
        logic [ID_W-1:0]      id;
        logic [TIME_BITS-1:0] ts;
    } stk_entry_t;

endpackage

// ----- hw/rtl/csx_sat_alu.sv -----
module csx_sat_alu (
    input  logic signed [csx_pkg::ALU_W-1:0]   a,
    input  logic signed [csx_pkg::ALU_W-1:0]   b,
    input  logic                               sub,
    input  logic                               inc,
    output logic signed [csx_pkg::TOTAL_W-1:0] sum_sat
);
    import csx_pkg::*;

    logic signed [ALU_W-1:0] b_op;
    logic        [1:0]       carry;
    logic signed [ALU_W-1:0] sum;

    // a + b or a - b, with an optional extra one
    assign b_op  = sub ? ~b : b;
    assign carry = {1'b0, sub} + {1'b0, inc};
    assign sum   = a + b_op + ALU_W'(carry);

    // clamp to the signed total range
    always_comb begin
        if (sum > TOTAL_MAX) begin
            sum_sat = TOTAL_MAX[TOTAL_W-1:0];
        end else if (sum < TOTAL_MIN) begin
            sum_sat = TOTAL_MIN[TOTAL_W-1:0];
        end else begin
            sum_sat = sum[TOTAL_W-1:0];
        end
    end

endmodule

// ----- hw/rtl/csx_stack_mem.sv -----
module csx_stack_mem (
    input  logic                        aclk,
    input  logic                        we,
    input  logic [csx_pkg::STK_AW-1:0]  waddr,
    input  csx_pkg::stk_entry_t         wdata,
    input  logic                        re,
    input  logic [csx_pkg::STK_AW-1:0]  raddr,
    output csx_pkg::stk_entry_t         rdata
);
    import csx_pkg::*;

    stk_entry_t mem [STACK_DEPTH];
    stk_entry_t rdata_reg;

    // entries below the depth are always written before they are read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/csx_total_mem.sv -----
module csx_total_mem (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               we,
    input  logic [csx_pkg::FID_AW-1:0]         waddr,
    input  logic signed [csx_pkg::TOTAL_W-1:0] wdata,
    input  logic                               re,
    input  logic [csx_pkg::FID_AW-1:0]         raddr,
    output logic signed [csx_pkg::TOTAL_W-1:0] rdata
);
    import csx_pkg::*;

    logic signed [TOTAL_W-1:0] mem [NUM_FUNCS];
    logic [NUM_FUNCS-1:0]      valid_reg;
    logic signed [TOTAL_W-1:0] rdata_reg;

    // per-entry valid bits stand in for clearing the table
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (we) begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, new data forwarded on a same-address write
    always_ff @(posedge aclk) begin
        if (re) begin
            if (we && (waddr == raddr)) begin
                rdata_reg <= wdata;
            end else if (valid_reg[raddr]) begin
                rdata_reg <= mem[raddr];
            end else begin
                rdata_reg <= '0;
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/call_stack_exclusive_timer.sv -----
// channel  | dir | valid / ready      | tdata                            | tuser
// ---------+-----+--------------------+----------------------------------+------------------
// s_       | in  | s_tvalid, s_tready | func_id, timestamp               | req_type, is_start
// m_       | out | m_tvalid, m_tready | result_id, total, depth_now      | status
// cfg_     | in  | cfg_we             | cfg_wdata: function_count        | -
//
// A read, a start or an end on an empty stack passes from acceptance through the
// top and done states, any other end through top, pop and done, adding the call
// state when a caller remains and its total is charged. The one port pair of the
// totals memory and the single saturating adder set these steps.
// s_tready is high only while the sequencer is idle; a result waiting in the
// output register does not block the next word, which then waits in the done
// state until the output register frees. Reset is synchronous; totals read as
// zero at once through per-entry valid bits, no clearing pass.
module call_stack_exclusive_timer (
    input  logic                              aclk,
    input  logic                              aresetn,
    // function_count
    input  logic                              cfg_we,
    input  logic [csx_pkg::FCOUNT_W-1:0]      cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [5:0] func_id, [37:6] timestamp, [39:38] zero
    input  logic [csx_pkg::S_TDATA_W-1:0]     s_tdata,
    // [0] req_type, [1] is_start
    input  logic [csx_pkg::S_TUSER_W-1:0]     s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [5:0] result_id, [45:6] total, [52:46] depth_now, [55:53] zero
    output logic [csx_pkg::M_TDATA_W-1:0]     m_tdata,
    // [2:0] status
    output logic [csx_pkg::M_TUSER_W-1:0]     m_tuser
);
    import csx_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TOP  = 3'd1;
    localparam logic [2:0] S_POP  = 3'd2;
    localparam logic [2:0] S_CALL = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]                state_reg, state_next;
    logic [FCOUNT_W-1:0]       fcount_reg;
    logic [DEPTH_W-1:0]        cnt_reg, cnt_next;
    logic                      req_reg, start_reg;
    logic [ID_W-1:0]           fid_reg;
    logic [TIME_BITS-1:0]      time_reg;
    logic [SPAN_W-1:0]         span_reg, span_next;
    logic                      back_reg, back_next;
    logic [ID_W-1:0]           res_id_reg, res_id_next;
    logic signed [TOTAL_W-1:0] res_total_reg, res_total_next;
    logic [STATUS_W-1:0]       res_status_reg, res_status_next;
    logic                      m_valid_reg;
    logic [M_TDATA_W-1:0]      m_data_reg;
    logic [M_TUSER_W-1:0]      m_user_reg;

    logic                      in_fire, out_load, fid_ok;
    logic [DEPTH_W-1:0]        top_idx, caller_idx;

    logic                      stk_we, stk_re;
    logic [STK_AW-1:0]         stk_waddr, stk_raddr;
    stk_entry_t                stk_wdata, stk_rdata;
    logic                      tot_we, tot_re;
    logic [FID_AW-1:0]         tot_waddr, tot_raddr;
    logic signed [TOTAL_W-1:0] tot_wdata, tot_rdata;

    logic signed [ALU_W-1:0]   alu_a, alu_b;
    logic                      alu_sub, alu_inc;
    logic signed [TOTAL_W-1:0] alu_sum;

    assign s_tready   = (state_reg == S_IDLE);
    assign in_fire    = s_tvalid && s_tready;
    assign top_idx    = cnt_reg - DEPTH_W'(1);
    assign caller_idx = cnt_reg - DEPTH_W'(2);
    assign fid_ok     = ({1'b0, fid_reg} < fcount_reg)
                        && ({1'b0, fid_reg} < (ID_W + 1)'(NUM_FUNCS));
    assign out_load   = (state_reg == S_DONE) && (!m_valid_reg || m_tready);

    csx_stack_mem u_stack (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    csx_total_mem u_totals (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (tot_we),
        .waddr   (tot_waddr),
        .wdata   (tot_wdata),
        .re      (tot_re),
        .raddr   (tot_raddr),
        .rdata   (tot_rdata)
    );

    csx_sat_alu u_alu (
        .a       (alu_a),
        .b       (alu_b),
        .sub     (alu_sub),
        .inc     (alu_inc),
        .sum_sat (alu_sum)
    );

    // adder operands: span in the top step, total +/- span afterwards
    always_comb begin
        case (state_reg)
            S_TOP: begin
                alu_a   = ALU_W'(time_reg);
                alu_b   = ALU_W'(stk_rdata.ts);
                alu_sub = 1'b1;
                alu_inc = 1'b1;
            end
            S_CALL: begin
                alu_a   = ALU_W'(tot_rdata);
                alu_b   = ALU_W'(span_reg);
                alu_sub = 1'b1;
                alu_inc = 1'b0;
            end
            default: begin
                alu_a   = ALU_W'(tot_rdata);
                alu_b   = ALU_W'(span_reg);
                alu_sub = 1'b0;
                alu_inc = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        span_next       = span_reg;
        back_next       = back_reg;
        res_id_next     = res_id_reg;
        res_total_next  = res_total_reg;
        res_status_next = res_status_reg;
        stk_we          = 1'b0;
        stk_waddr       = cnt_reg[STK_AW-1:0];
        stk_wdata       = '{id: fid_reg, ts: time_reg};
        stk_re          = 1'b0;
        stk_raddr       = top_idx[STK_AW-1:0];
        tot_we          = 1'b0;
        tot_waddr       = res_id_reg[FID_AW-1:0];
        tot_wdata       = alu_sum;
        tot_re          = 1'b0;
        tot_raddr       = s_tdata[FID_AW-1:0];
        case (state_reg)
            S_IDLE: begin
                // fetch the top entry and the requested total
                if (in_fire) begin
                    stk_re     = 1'b1;
                    tot_re     = 1'b1;
                    state_next = S_TOP;
                end
            end
            S_TOP: begin
                res_id_next = fid_reg;
                state_next  = S_DONE;
                if (req_reg || start_reg) begin
                    if (!fid_ok) begin
                        res_status_next = STAT_RANGE;
                        res_total_next  = '0;
                    end else if (req_reg) begin
                        res_status_next = STAT_OK;
                        res_total_next  = tot_rdata;
                    end else if (cnt_reg == DEPTH_W'(STACK_DEPTH)) begin
                        res_status_next = STAT_FULL;
                        res_total_next  = tot_rdata;
                    end else begin
                        stk_we          = 1'b1;
                        cnt_next        = cnt_reg + DEPTH_W'(1);
                        res_status_next = STAT_OK;
                        res_total_next  = tot_rdata;
                    end
                end else if (cnt_reg == '0) begin
                    res_id_next     = '0;
                    res_status_next = STAT_EMPTY;
                    res_total_next  = '0;
                end else begin
                    // end event: span = t - t0 + 1, backwards when not positive
                    res_id_next = stk_rdata.id;
                    span_next   = alu_sum[SPAN_W-1:0];
                    back_next   = alu_sum[TOTAL_W-1] || (alu_sum == '0);
                    tot_re      = 1'b1;
                    tot_raddr   = stk_rdata.id[FID_AW-1:0];
                    stk_re      = 1'b1;
                    stk_raddr   = caller_idx[STK_AW-1:0];
                    state_next  = S_POP;
                end
            end
            S_POP: begin
                state_next = S_DONE;
                if (back_reg) begin
                    res_status_next = STAT_BACK;
                    res_total_next  = tot_rdata;
                end else begin
                    // credit the popped function
                    tot_we          = 1'b1;
                    res_status_next = STAT_OK;
                    res_total_next  = alu_sum;
                    cnt_next        = top_idx;
                    if (cnt_reg > DEPTH_W'(1)) begin
                        tot_re     = 1'b1;
                        tot_raddr  = stk_rdata.id[FID_AW-1:0];
                        state_next = S_CALL;
                    end
                end
            end
            S_CALL: begin
                // charge the caller; a recursive caller is the credited function
                tot_we     = 1'b1;
                tot_waddr  = stk_rdata.id[FID_AW-1:0];
                if (stk_rdata.id == res_id_reg) begin
                    res_total_next = alu_sum;
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            fcount_reg  <= FCOUNT_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_we) begin
                fcount_reg <= cfg_wdata;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            req_reg   <= s_tuser[0];
            start_reg <= s_tuser[1];
            fid_reg   <= s_tdata[ID_W-1:0];
            time_reg  <= s_tdata[ID_W +: TIME_BITS];
        end
        span_reg       <= span_next;
        back_reg       <= back_next;
        res_id_reg     <= res_id_next;
        res_total_reg  <= res_total_next;
        res_status_reg <= res_status_next;
        if (out_load) begin
            m_data_reg <= {3'b000, cnt_reg, res_total_reg, res_id_reg};
            m_user_reg <= res_status_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ----- hw/rtl/csx_checker.sv -----
module csx_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [csx_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [csx_pkg::M_TUSER_W-1:0] m_tuser
);
    import csx_pkg::*;

    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // status is a defined code
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= STAT_BACK)
        else $error("undefined status code");

    // empty stack end: id, total and depth are all zero
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STAT_EMPTY) |-> m_tdata[52:0] == '0)
        else $error("empty-stack result not zero");

    // out of range id reports a zero total
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STAT_RANGE) |-> m_tdata[45:6] == '0)
        else $error("out-of-range id with nonzero total");

    // depth never exceeds the stack size
    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[52:46] <= DEPTH_W'(STACK_DEPTH))
        else $error("depth beyond stack size");

endmodule

bind call_stack_exclusive_timer csx_checker u_csx_checker (.*);
